// ===== design/cft_pkg.sv =====
// Shared constants, types, op codes and arithmetic helpers for the chorus/flanger/tremolo block.
package cft_pkg;

  localparam int DELAY_DEPTH  = 8192;
  localparam int SAMPLE_BITS  = 24;
  localparam int SINE_ENTRIES = 1024;

  localparam int AW      = $clog2(DELAY_DEPTH);
  localparam int SIDX_W  = $clog2(SINE_ENTRIES);
  localparam int PHASE_W = 32;
  localparam int LFO_W   = 17;
  localparam int COEF_W  = 17;
  localparam int DW      = AW + 16;
  localparam int MA_W    = (SAMPLE_BITS > 22) ? SAMPLE_BITS : 22;
  localparam int MB_W    = 19;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MEM_W   = 2 * SAMPLE_BITS;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOLO_ON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIX        = 3'd6;

  localparam longint D_LO = 64'sd65536;
  localparam longint D_HI = longint'(DELAY_DEPTH - 100) * 64'sd65536;
  localparam longint RP_WRAP = longint'(DELAY_DEPTH) <<< 16;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE = 5'd0;
  localparam logic [OP_W-1:0] OP_LFO  = 5'd1;
  localparam logic [OP_W-1:0] OP_MLD  = 5'd2;
  localparam logic [OP_W-1:0] OP_G    = 5'd3;
  localparam logic [OP_W-1:0] OP_MBF  = 5'd4;
  localparam logic [OP_W-1:0] OP_WT   = 5'd5;
  localparam logic [OP_W-1:0] OP_RP   = 5'd6;
  localparam logic [OP_W-1:0] OP_RD0  = 5'd7;
  localparam logic [OP_W-1:0] OP_RD1  = 5'd8;
  localparam logic [OP_W-1:0] OP_IL0  = 5'd9;
  localparam logic [OP_W-1:0] OP_IL1  = 5'd10;
  localparam logic [OP_W-1:0] OP_IR0  = 5'd11;
  localparam logic [OP_W-1:0] OP_IR1  = 5'd12;
  localparam logic [OP_W-1:0] OP_FL   = 5'd13;
  localparam logic [OP_W-1:0] OP_FR   = 5'd14;
  localparam logic [OP_W-1:0] OP_ML0  = 5'd15;
  localparam logic [OP_W-1:0] OP_ML1  = 5'd16;
  localparam logic [OP_W-1:0] OP_WR   = 5'd17;
  localparam logic [OP_W-1:0] OP_MR0  = 5'd18;
  localparam logic [OP_W-1:0] OP_MR1  = 5'd19;
  localparam logic [OP_W-1:0] OP_TL   = 5'd20;
  localparam logic [OP_W-1:0] OP_TR   = 5'd21;
  localparam logic [OP_W-1:0] OP_FIN  = 5'd22;
  localparam logic [OP_W-1:0] OP_DONE = 5'd23;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [LFO_W-1:0] sine_tab_t [SINE_ENTRIES];

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
    logic            push;
  } cmd_t;

  typedef struct packed {
    logic delay_on;
    logic trem_on;
  } status_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic sine_tab_t make_sine();
    sine_tab_t t;
    logic [63:0] p, q, r, x, x2, mag, v;
    logic signed [64:0] sum;
    logic signed [17:0] sv;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      p = (64'(k) << 32) / SINE_ENTRIES;
      q = p >> 30;
      r = p & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      sum = $signed({1'b0, x});
      mag = ((x * x2) >> 30) / 6;
      sum = sum - $signed({1'b0, mag});
      mag = ((mag * x2) >> 30) / 20;
      sum = sum + $signed({1'b0, mag});
      mag = ((mag * x2) >> 30) / 42;
      sum = sum - $signed({1'b0, mag});
      mag = ((mag * x2) >> 30) / 72;
      sum = sum + $signed({1'b0, mag});
      mag = ((mag * x2) >> 30) / 110;
      sum = sum - $signed({1'b0, mag});
      if (sum < 0) sum = '0;
      v = 64'((sum + 65'sd16384) >>> 15);
      if (v > 64'd32768) v = 64'd32768;
      sv = $signed({1'b0, v[16:0]});
      t[k] = q[1] ? 17'(-sv) : 17'(sv);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = make_sine();

  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    return (v + ACC_W'(32768)) >>> 16;
  endfunction

  function automatic sample_t sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] smax, smin;
    smax = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    smin = -smax - ACC_W'(1);
    if (v > smax) return smax[SAMPLE_BITS-1:0];
    if (v < smin) return smin[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== design/chorus_flanger_tremolo.sv =====
// Top level of the stereo chorus/flanger with tremolo.
//
// Input words (left_in, right_in, restart) enter on in_valid/in_ready and
// result words (left_out, right_out) leave on out_valid/out_ready. A word is
// taken only while the block is idle, so one word is in work at a time.
// With the delay on, the single shared multiplier, used for every product
// in turn, and the two reads of the delay store per word set how long a
// word takes, and tremolo adds its own products on top. Tremolo alone
// skips the delay steps, and with both effects off the word is passed
// straight through. The next word is accepted in the cycle after the
// result is pushed. The result sits in an output register, so the
// next word is accepted while a finished result waits; if the receiver
// stalls, the block holds its next result until the register is free.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, as the block does not enforce it. Reset
// restores the register defaults and empties the delay store; a word with
// restart set, unless both effects are off, does the same for the store, the
// write pointer and LFO phase, as entries not written since then read as zero.
module chorus_flanger_tremolo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cft_pkg::sample_t               left_in,
  input  cft_pkg::sample_t               right_in,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cft_pkg::sample_t               left_out,
  output cft_pkg::sample_t               right_out,
  input  logic                           cfg_we,
  input  logic [cft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data
);

  cft_pkg::cmd_t    cmd;
  cft_pkg::status_t status;

  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cft_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .left_in  (left_in),
    .right_in (right_in),
    .restart  (restart),
    .left_out (left_out),
    .right_out(right_out),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block still idle after taking a word");

  a_push_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result pushed over a pending word");

  a_push_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid)
    else $error("pushed result not presented");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_ready)
    else $error("word loaded while busy");

endmodule

// ===== design/cft_ram.sv =====
// Generic single write port RAM with one registered read port.
module cft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cft_ctrl.sv =====
// Sequencing state machine that steps the datapath through one stereo word.
module cft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cft_pkg::status_t status,
  output cft_pkg::cmd_t    cmd
);

  logic [cft_pkg::OP_W-1:0] state, state_next;
  logic out_valid_next;
  logic bypass;

  assign bypass = !status.delay_on && !status.trem_on;
  assign in_ready = (state == cft_pkg::OP_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = state;
    cmd.load = 1'b0;
    cmd.push = 1'b0;
    unique case (state)
      cft_pkg::OP_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = bypass ? cft_pkg::OP_DONE : cft_pkg::OP_LFO;
        end
      end
      cft_pkg::OP_LFO: state_next = status.delay_on ? cft_pkg::OP_MLD : cft_pkg::OP_G;
      cft_pkg::OP_MLD: state_next = cft_pkg::OP_G;
      cft_pkg::OP_G:   state_next = status.delay_on ? cft_pkg::OP_MBF : cft_pkg::OP_WR;
      cft_pkg::OP_MBF: state_next = cft_pkg::OP_WT;
      cft_pkg::OP_WT:  state_next = cft_pkg::OP_RP;
      cft_pkg::OP_RP:  state_next = cft_pkg::OP_RD0;
      cft_pkg::OP_RD0: state_next = cft_pkg::OP_RD1;
      cft_pkg::OP_RD1: state_next = cft_pkg::OP_IL0;
      cft_pkg::OP_IL0: state_next = cft_pkg::OP_IL1;
      cft_pkg::OP_IL1: state_next = cft_pkg::OP_IR0;
      cft_pkg::OP_IR0: state_next = cft_pkg::OP_IR1;
      cft_pkg::OP_IR1: state_next = cft_pkg::OP_FL;
      cft_pkg::OP_FL:  state_next = cft_pkg::OP_FR;
      cft_pkg::OP_FR:  state_next = cft_pkg::OP_ML0;
      cft_pkg::OP_ML0: state_next = cft_pkg::OP_ML1;
      cft_pkg::OP_ML1: state_next = cft_pkg::OP_WR;
      cft_pkg::OP_WR:  state_next = status.delay_on ? cft_pkg::OP_MR0 : cft_pkg::OP_TL;
      cft_pkg::OP_MR0: state_next = cft_pkg::OP_MR1;
      cft_pkg::OP_MR1: state_next = status.trem_on ? cft_pkg::OP_TL : cft_pkg::OP_FIN;
      cft_pkg::OP_TL:  state_next = cft_pkg::OP_TR;
      cft_pkg::OP_TR:  state_next = cft_pkg::OP_FIN;
      cft_pkg::OP_FIN: state_next = cft_pkg::OP_DONE;
      cft_pkg::OP_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.push = 1'b1;
          state_next = cft_pkg::OP_IDLE;
        end
      end
      default: state_next = cft_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cft_pkg::OP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/cft_dp.sv =====
// Datapath: configuration registers, LFO, delay store, shared multiplier and result registers.
module cft_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  cft_pkg::cmd_t                     cmd,
  output cft_pkg::status_t                  status,
  input  cft_pkg::sample_t                  left_in,
  input  cft_pkg::sample_t                  right_in,
  input  logic                              restart,
  output cft_pkg::sample_t                  left_out,
  output cft_pkg::sample_t                  right_out,
  input  logic                              cfg_we,
  input  logic [cft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cft_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = cft_pkg::AW;
  localparam int DW = cft_pkg::DW;
  localparam int PW = cft_pkg::PROD_W;
  localparam int CW = cft_pkg::ACC_W;
  localparam int SB = cft_pkg::SAMPLE_BITS;

  logic        delay_on, trem_on;
  logic [23:0] phase_step;
  logic [16:0] depth, mix;
  logic [15:0] feedback;
  logic [20:0] base_delay;

  logic [cft_pkg::PHASE_W-1:0] phase;
  logic [AW-1:0]               wp;
  logic                        wrapped;
  logic [cft_pkg::OP_W-1:0]    op_d;

  cft_pkg::sample_t l, r, res_l, res_r, s0l, s0r, s1l, s1r, dl, dr, wl, wr;
  logic signed [cft_pkg::LFO_W-1:0] lfo;
  logic [17:0]          fac;
  logic [16:0]          g;
  logic [DW-1:0]        d;
  logic [AW-1:0]        idx;
  logic [15:0]          frac;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] acc;
  logic                 rd_ok;

  logic [16:0] dep_sat, mix_sat;
  logic signed [cft_pkg::MA_W-1:0] a_op;
  logic signed [cft_pkg::MB_W-1:0] b_op;
  logic signed [CW-1:0] sum, prod_x;
  logic signed [PW-1:0] fac_full, g_full, dsh;
  logic signed [DW:0]   rp, rp_w;
  logic [17:0]          lfo_off;
  logic [AW-1:0]        jdx, raddr;
  logic                 mem_we;
  logic [cft_pkg::MEM_W-1:0] wdata, rdata;

  assign status.delay_on = delay_on;
  assign status.trem_on = trem_on;

  assign dep_sat = (depth > 17'h10000) ? 17'h10000 : depth;
  assign mix_sat = (mix > 17'h10000) ? 17'h10000 : mix;
  assign lfo_off = 18'($signed({lfo[16], lfo}) + 18'sd32768);

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.op)
      cft_pkg::OP_MLD: begin
        a_op = cft_pkg::MA_W'(lfo);
        b_op = cft_pkg::MB_W'($signed({1'b0, dep_sat}));
      end
      cft_pkg::OP_G: begin
        a_op = cft_pkg::MA_W'($signed({1'b0, dep_sat}));
        b_op = cft_pkg::MB_W'($signed({1'b0, lfo_off}));
      end
      cft_pkg::OP_MBF: begin
        a_op = cft_pkg::MA_W'($signed({1'b0, base_delay}));
        b_op = cft_pkg::MB_W'($signed({1'b0, fac}));
      end
      cft_pkg::OP_IL0: begin
        a_op = cft_pkg::MA_W'(s0l);
        b_op = cft_pkg::MB_W'($signed(18'h10000 - {2'b0, frac}));
      end
      cft_pkg::OP_IL1: begin
        a_op = cft_pkg::MA_W'(s1l);
        b_op = cft_pkg::MB_W'($signed({1'b0, frac}));
      end
      cft_pkg::OP_IR0: begin
        a_op = cft_pkg::MA_W'(s0r);
        b_op = cft_pkg::MB_W'($signed(18'h10000 - {2'b0, frac}));
      end
      cft_pkg::OP_IR1: begin
        a_op = cft_pkg::MA_W'(s1r);
        b_op = cft_pkg::MB_W'($signed({1'b0, frac}));
      end
      cft_pkg::OP_FL: begin
        a_op = cft_pkg::MA_W'(dl);
        b_op = cft_pkg::MB_W'($signed({1'b0, feedback}));
      end
      cft_pkg::OP_FR: begin
        a_op = cft_pkg::MA_W'(dr);
        b_op = cft_pkg::MB_W'($signed({1'b0, feedback}));
      end
      cft_pkg::OP_ML0: begin
        a_op = cft_pkg::MA_W'(l);
        b_op = cft_pkg::MB_W'($signed(18'h10000 - {1'b0, mix_sat}));
      end
      cft_pkg::OP_ML1: begin
        a_op = cft_pkg::MA_W'(dl);
        b_op = cft_pkg::MB_W'($signed({1'b0, mix_sat}));
      end
      cft_pkg::OP_MR0: begin
        a_op = cft_pkg::MA_W'(r);
        b_op = cft_pkg::MB_W'($signed(18'h10000 - {1'b0, mix_sat}));
      end
      cft_pkg::OP_MR1: begin
        a_op = cft_pkg::MA_W'(dr);
        b_op = cft_pkg::MB_W'($signed({1'b0, mix_sat}));
      end
      cft_pkg::OP_TL: begin
        a_op = cft_pkg::MA_W'(res_l);
        b_op = cft_pkg::MB_W'($signed({1'b0, g}));
      end
      cft_pkg::OP_TR: begin
        a_op = cft_pkg::MA_W'(res_r);
        b_op = cft_pkg::MB_W'($signed({1'b0, g}));
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_x = CW'(prod);
  assign sum = acc + prod_x;
  assign fac_full = (prod >>> 16) + PW'(65536);
  assign g_full = PW'(65536) - ((prod + PW'(32768)) >>> 16);
  assign dsh = prod >>> 8;
  assign rp = $signed({1'b0, wp, 16'h0000}) - $signed({1'b0, d});
  assign rp_w = (rp < 0) ? rp + (DW + 1)'(cft_pkg::RP_WRAP) : rp;

  assign jdx = (idx == AW'(cft_pkg::DELAY_DEPTH - 1)) ? '0 : idx + AW'(1);
  assign raddr = (cmd.op == cft_pkg::OP_RD1) ? jdx : idx;
  assign mem_we = (cmd.op == cft_pkg::OP_WR);
  assign wdata = delay_on ? {wl, wr} : {l, r};

  cft_ram #(
    .WIDTH(cft_pkg::MEM_W),
    .DEPTH(cft_pkg::DELAY_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wp),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_on <= 1'b1;
      trem_on <= 1'b0;
      phase_step <= 24'd4194;
      depth <= 17'd32768;
      feedback <= 16'd0;
      base_delay <= 21'd122880;
      mix <= 17'd32768;
      phase <= '0;
      wp <= '0;
      wrapped <= 1'b0;
      op_d <= cft_pkg::OP_IDLE;
    end else begin
      op_d <= cmd.op;
      if (cfg_we) begin
        unique case (cfg_index)
          cft_pkg::REG_DELAY_ON:   delay_on <= cfg_data[0];
          cft_pkg::REG_TREMOLO_ON: trem_on <= cfg_data[0];
          cft_pkg::REG_PHASE_STEP: phase_step <= cfg_data[23:0];
          cft_pkg::REG_DEPTH:      depth <= cfg_data[16:0];
          cft_pkg::REG_FEEDBACK:   feedback <= cfg_data[15:0];
          cft_pkg::REG_BASE_DELAY: base_delay <= cfg_data[20:0];
          cft_pkg::REG_MIX:        mix <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (cmd.load && restart && (delay_on || trem_on)) begin
        phase <= '0;
        wp <= '0;
        wrapped <= 1'b0;
      end
      if (cmd.op == cft_pkg::OP_LFO) begin
        phase <= phase + {8'h00, phase_step};
      end
      if (mem_we) begin
        wp <= (wp == AW'(cft_pkg::DELAY_DEPTH - 1)) ? '0 : wp + AW'(1);
        if (wp == AW'(cft_pkg::DELAY_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    rd_ok <= wrapped || (raddr < wp);
    if (cmd.load) begin
      l <= left_in;
      r <= right_in;
      res_l <= left_in;
      res_r <= right_in;
    end
    if (cmd.op == cft_pkg::OP_LFO) begin
      lfo <= cft_pkg::SINE_TAB[phase[cft_pkg::PHASE_W-1 -: cft_pkg::SIDX_W]];
    end
    if (cmd.op == cft_pkg::OP_RP) begin
      idx <= rp_w[DW-1:16];
      frac <= rp_w[15:0];
    end
    if (cmd.push) begin
      left_out <= res_l;
      right_out <= res_r;
    end
    case (op_d)
      cft_pkg::OP_MLD: fac <= fac_full[17:0];
      cft_pkg::OP_G:   g <= g_full[16:0];
      cft_pkg::OP_MBF: begin
        if (dsh < PW'(cft_pkg::D_LO)) begin
          d <= DW'(cft_pkg::D_LO);
        end else if (dsh > PW'(cft_pkg::D_HI)) begin
          d <= DW'(cft_pkg::D_HI);
        end else begin
          d <= dsh[DW-1:0];
        end
      end
      cft_pkg::OP_RD0: begin
        s0l <= rd_ok ? rdata[2*SB-1:SB] : '0;
        s0r <= rd_ok ? rdata[SB-1:0] : '0;
      end
      cft_pkg::OP_RD1: begin
        s1l <= rd_ok ? rdata[2*SB-1:SB] : '0;
        s1r <= rd_ok ? rdata[SB-1:0] : '0;
      end
      cft_pkg::OP_IL0, cft_pkg::OP_IR0, cft_pkg::OP_ML0, cft_pkg::OP_MR0: acc <= prod_x;
      cft_pkg::OP_IL1: dl <= cft_pkg::sat_smp(cft_pkg::rnd16(sum));
      cft_pkg::OP_IR1: dr <= cft_pkg::sat_smp(cft_pkg::rnd16(sum));
      cft_pkg::OP_FL:  wl <= cft_pkg::sat_smp(CW'(l) + cft_pkg::rnd16(prod_x));
      cft_pkg::OP_FR:  wr <= cft_pkg::sat_smp(CW'(r) + cft_pkg::rnd16(prod_x));
      cft_pkg::OP_ML1: res_l <= cft_pkg::sat_smp(cft_pkg::rnd16(sum));
      cft_pkg::OP_MR1: res_r <= cft_pkg::sat_smp(cft_pkg::rnd16(sum));
      cft_pkg::OP_TL:  res_l <= cft_pkg::sat_smp(cft_pkg::rnd16(prod_x));
      cft_pkg::OP_TR:  res_r <= cft_pkg::sat_smp(cft_pkg::rnd16(prod_x));
      default: ;
    endcase
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the stereo chorus/flanger/tremolo block: a local predictor checks every result word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  cft_pkg::sample_t left_in = '0;
  cft_pkg::sample_t right_in = '0;
  logic restart = 0;
  logic out_valid;
  logic out_ready = 0;
  cft_pkg::sample_t left_out, right_out;
  logic cfg_we = 0;
  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  chorus_flanger_tremolo u_top (.*);

  initial forever #1 clk = ~clk;

  typedef struct {
    cft_pkg::sample_t l;
    cft_pkg::sample_t r;
  } stereo_t;

  stereo_t expected_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int restarts_sent = 0;
  longint cycles = 0;
  bit hold_off = 0;

  // Predictor state and settings.
  int sine_lut[cft_pkg::SINE_ENTRIES];
  longint store_l[cft_pkg::DELAY_DEPTH];
  longint store_r[cft_pkg::DELAY_DEPTH];
  int unsigned wr_ptr;
  bit [31:0] phase_acc;
  bit p_delay_on, p_trem_on;
  longint p_step, p_depth, p_fb, p_base, p_mix;

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint rshift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic int sine_at(longint unsigned p);
    longint unsigned q, r, x, x2, mag;
    longint sum, v;
    q = p >> 30;
    r = p & 64'h3FFF_FFFF;
    if (q[0]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    mag = x;
    sum = x;
    for (int n = 1; n <= 5; n++) begin
      mag = ((mag * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= mag; else sum += mag;
    end
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32768) v = 32768;
    return (q >= 2) ? -int'(v) : int'(v);
  endfunction

  task automatic clear_store();
    for (int k = 0; k < cft_pkg::DELAY_DEPTH; k++) begin
      store_l[k] = 0;
      store_r[k] = 0;
    end
    wr_ptr = 0;
    phase_acc = 0;
  endtask

  function automatic longint interp(ref longint s[cft_pkg::DELAY_DEPTH],
                                    input int unsigned i, input longint f);
    int unsigned j;
    j = (i + 1 >= cft_pkg::DELAY_DEPTH) ? 0 : i + 1;
    return rshift(s[i] * (65536 - f) + s[j] * f, 16);
  endfunction

  task automatic process_sample(input cft_pkg::sample_t li, input cft_pkg::sample_t ri,
                                input bit rs);
    longint l, r, lfo, dep, m, fac, d, rp, dl, dr, g, f;
    int unsigned i;
    l = li;
    r = ri;
    if (p_delay_on || p_trem_on) begin
      if (rs) clear_store();
      lfo = sine_lut[phase_acc[31:22]];
      phase_acc = phase_acc + 32'(p_step);
      dep = (p_depth > 65536) ? 65536 : p_depth;
      m = (p_mix > 65536) ? 65536 : p_mix;
      if (p_delay_on) begin
        fac = 65536 + fshift(lfo * dep, 16);
        d = (p_base * fac) >>> 8;
        if (d < 65536) d = 65536;
        if (d > longint'(cft_pkg::DELAY_DEPTH - 100) * 65536)
          d = longint'(cft_pkg::DELAY_DEPTH - 100) * 65536;
        rp = longint'(wr_ptr) * 65536 - d;
        if (rp < 0) rp += longint'(cft_pkg::DELAY_DEPTH) * 65536;
        i = rp >>> 16;
        f = rp & 64'hFFFF;
        if (i >= cft_pkg::DELAY_DEPTH) i -= cft_pkg::DELAY_DEPTH;
        dl = interp(store_l, i, f);
        dr = interp(store_r, i, f);
        store_l[wr_ptr] = clip(l + rshift(dl * p_fb, 16));
        store_r[wr_ptr] = clip(r + rshift(dr * p_fb, 16));
        l = clip(rshift(l * (65536 - m) + dl * m, 16));
        r = clip(rshift(r * (65536 - m) + dr * m, 16));
      end else begin
        store_l[wr_ptr] = l;
        store_r[wr_ptr] = r;
      end
      wr_ptr = (wr_ptr + 1 >= cft_pkg::DELAY_DEPTH) ? 0 : wr_ptr + 1;
      if (p_trem_on) begin
        g = 65536 - ((dep * (lfo + 32768) + 32768) >>> 16);
        l = clip(rshift(l * g, 16));
        r = clip(rshift(r * g, 16));
      end
    end
    expected_q.push_back('{l: cft_pkg::sample_t'(l), r: cft_pkg::sample_t'(r)});
  endtask

  task automatic write_reg(input logic [cft_pkg::CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= cft_pkg::CFG_DATA_W'(val);
    case (idx)
      cft_pkg::REG_DELAY_ON: p_delay_on = val[0];
      cft_pkg::REG_TREMOLO_ON: p_trem_on = val[0];
      cft_pkg::REG_PHASE_STEP: p_step = val & 24'hFFFFFF;
      cft_pkg::REG_DEPTH: p_depth = val & 17'h1FFFF;
      cft_pkg::REG_FEEDBACK: p_fb = val & 16'hFFFF;
      cft_pkg::REG_BASE_DELAY: p_base = val & 21'h1FFFFF;
      cft_pkg::REG_MIX: p_mix = val & 17'h1FFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // The word stays valid after acceptance until the next call or drain() drops it.
  task automatic send_sample(input cft_pkg::sample_t li, input cft_pkg::sample_t ri,
                             input bit rs);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    left_in <= li;
    right_in <= ri;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    process_sample(li, ri, rs);
    words_sent++;
    if (rs) restarts_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic cft_pkg::sample_t rnd_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return cft_pkg::sample_t'($urandom_range(0, 2000)) - 1000;
      default: return cft_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(cft_pkg::REG_DELAY_ON, $urandom_range(0, 5) != 0);
    write_reg(cft_pkg::REG_TREMOLO_ON, $urandom_range(0, 1));
    write_reg(cft_pkg::REG_PHASE_STEP,
              $urandom_range(0, 3) == 0 ? 24'hFFFFFF : $urandom_range(0, 200000));
    write_reg(cft_pkg::REG_DEPTH,
              $urandom_range(0, 4) == 0 ? 17'h1FFFF : $urandom_range(0, 65536));
    write_reg(cft_pkg::REG_FEEDBACK,
              $urandom_range(0, 4) == 0 ? 16'hFFFF : $urandom_range(0, 62259));
    write_reg(cft_pkg::REG_BASE_DELAY,
              $urandom_range(0, 4) == 0 ? 21'h1FFFFF : $urandom_range(0, 600000));
    write_reg(cft_pkg::REG_MIX,
              $urandom_range(0, 4) == 0 ? 17'h1FFFF : $urandom_range(0, 65536));
  endtask

  task automatic test_directed();
    send_sample(24'sh7FFFFF, 24'sh800000, 0);
    send_sample(24'sh800000, 24'sh7FFFFF, 0);
    send_sample(0, 0, 1);
    send_sample(24'sh3FFFFF, -24'sh3FFFFF, 0);
    drain();
    write_reg(cft_pkg::REG_BASE_DELAY, 256);
    write_reg(cft_pkg::REG_FEEDBACK, 62259);
    write_reg(cft_pkg::REG_MIX, 65536);
    for (int k = 0; k < 5; k++) send_sample(24'sh7FFFFF, 24'sh800000, 0);
    drain();
    write_reg(cft_pkg::REG_BASE_DELAY, 21'h1FFFFF);
    write_reg(cft_pkg::REG_DEPTH, 17'h1FFFF);
    write_reg(cft_pkg::REG_MIX, 17'h1FFFF);
    write_reg(cft_pkg::REG_FEEDBACK, 16'hFFFF);
    write_reg(cft_pkg::REG_PHASE_STEP, 24'hFFFFFF);
    write_reg(cft_pkg::REG_TREMOLO_ON, 1);
    for (int k = 0; k < 4; k++) send_sample(24'sh7FFFFF, 24'sh800000, k == 2);
    drain();
    write_reg(cft_pkg::REG_DELAY_ON, 0);
    send_sample(24'sh123456, 24'sh800000, 0);
    send_sample(24'sh7FFFFF, 24'sh000001, 1);
    drain();
    write_reg(cft_pkg::REG_TREMOLO_ON, 0);
    write_reg(cft_pkg::REG_BASE_DELAY, 0);
    write_reg(cft_pkg::REG_DEPTH, 0);
    write_reg(cft_pkg::REG_MIX, 0);
    write_reg(cft_pkg::REG_PHASE_STEP, 0);
    send_sample(24'sh555555, 24'shAAAAAA, 1);
    send_sample(24'sh7FFFFF, 24'sh800000, 0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int k = 0; k < 6; k++) send_sample(rnd_sample(), rnd_sample(), 0);
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 16; ph++) begin
      random_config();
      for (int k = 0; k < 100; k++)
        send_sample(rnd_sample(), rnd_sample(), $urandom_range(0, 60) == 0);
      drain();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n != 0) begin
        out_ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      out_ready <= 0;
    end
  end

  always @(posedge clk) begin
    stereo_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word L=%0d R=%0d", $time, left_out, right_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        if (left_out !== e.l) begin
          $display("%0t: left expected %0d actual %0d", $time, e.l, left_out);
          errors++;
        end
        if (right_out !== e.r) begin
          $display("%0t: right expected %0d actual %0d", $time, e.r, right_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < cft_pkg::SINE_ENTRIES; k++)
      sine_lut[k] = sine_at((longint'(k) << 32) / cft_pkg::SINE_ENTRIES);
    clear_store();
    p_delay_on = 1; p_trem_on = 0; p_step = 4194; p_depth = 32768;
    p_fb = 0; p_base = 122880; p_mix = 32768;
    repeat (4) @(posedge clk);
    rst <= 0;
    test_directed();
    test_backpressure();
    test_random();
    if (expected_q.size() != 0) errors++;
    $display("Checked %0d of %0d stereo words, %0d with restart, over 16 random settings.",
             words_checked, words_sent, restarts_sent);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
